FILE: rtl/tnwc_pkg.sv
`default_nettype none
package tnwc_pkg;

  localparam int WindowBitsDefault = 32;
  localparam int SeqBits = 32;
  localparam int MssBits = 14;

  localparam logic [2:0] OP_OPEN     = 3'd0;
  localparam logic [2:0] OP_NEW_ACK  = 3'd1;
  localparam logic [2:0] OP_DUP_ACK  = 3'd2;
  localparam logic [2:0] OP_TIMEOUT  = 3'd3;
  localparam logic [2:0] OP_FREEZE   = 3'd4;
  localparam logic [2:0] OP_UNFREEZE = 3'd5;

  localparam logic [1:0] PHASE_CLOSED      = 2'd0;
  localparam logic [1:0] PHASE_ESTABLISHED = 2'd2;

  localparam logic [2:0] REG_MSS    = 3'd0;
  localparam logic [2:0] REG_DUPTH  = 3'd1;
  localparam logic [2:0] REG_LTX    = 3'd2;
  localparam logic [2:0] REG_IWND   = 3'd3;
  localparam logic [2:0] REG_ITHR   = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture event, apply the opcode's direct updates
    logic ack_pre;   // new ACK: leave recovery / pick growth path
    logic div_start; // start congestion avoidance divide
    logic div_step;  // one quotient bit
    logic ca_apply;  // apply the divide result
    logic emit;      // load output register
  } tnwc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;  // congestion avoidance growth needed
    logic div_done;
  } tnwc_sts_t;

endpackage
`default_nettype wire

FILE: rtl/tnwc_ctrl.sv
`default_nettype none
module tnwc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  input  wire tnwc_pkg::tnwc_sts_t sts,
  output tnwc_pkg::tnwc_cmd_t    cmd,
  output logic                   busy
);
  import tnwc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CA   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.ack_pre = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_CA;
      end
      S_CA: begin
        cmd.ca_apply = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/tnwc_dp.sv
`default_nettype none
module tnwc_dp #(
  parameter int WINDOW_BITS = tnwc_pkg::WindowBitsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tnwc_pkg::tnwc_cmd_t    cmd,
  output tnwc_pkg::tnwc_sts_t         sts,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_addr,
  input  wire logic [31:0]            cfg_wdata,
  input  wire logic [2:0]             ev_op,
  input  wire logic [31:0]            ev_ack,
  input  wire logic [31:0]            ev_head,
  input  wire logic [31:0]            ev_high,
  input  wire logic [31:0]            ev_flight,
  input  wire logic [7:0]             ev_dups,
  input  wire logic                   ev_unsent,
  input  wire logic [1:0]             ev_phase,
  input  wire logic [31:0]            ev_pwin,
  output logic [WINDOW_BITS-1:0]      res_cwnd,
  output logic [WINDOW_BITS-1:0]      res_ssth,
  output logic [WINDOW_BITS-1:0]      res_swnd,
  output logic [6:0]                  res_flags
);
  import tnwc_pkg::*;

  localparam int W = WINDOW_BITS;
  localparam int DivCntBits = $clog2(2 * MssBits + 1);
  localparam logic [W:0] WinMax = {1'b0, {W{1'b1}}};

  function automatic logic [W-1:0] clampw(input logic [32:0] v);
    logic [32:0] m;
    m = 33'(WinMax);
    clampw = (v > m) ? W'(m) : W'(v);
  endfunction

  function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    seq_lt = d[31];
  endfunction

  // Configuration.
  logic [MssBits-1:0] mss_r;
  logic [7:0]  dupth_r;
  logic        ltx_r;
  logic [4:0]  iwnd_r;
  logic [31:0] ithr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r <= MssBits'(536);
      dupth_r <= 8'd3;
      ltx_r <= 1'b0;
      iwnd_r <= 5'd1;
      ithr_r <= 32'd65535;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MSS:   mss_r <= cfg_wdata[MssBits-1:0];
        REG_DUPTH: dupth_r <= cfg_wdata[7:0];
        REG_LTX:   ltx_r <= cfg_wdata[0];
        REG_IWND:  iwnd_r <= cfg_wdata[4:0];
        REG_ITHR:  ithr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Connection state.
  logic [W-1:0] cwnd_r, cwnd_nxt, ssth_r, ssth_nxt, pwin_r, pwin_nxt;
  logic [W-1:0] scwnd_r, scwnd_nxt, sssth_r, sssth_nxt, spwin_r, spwin_nxt;
  logic         rec_r, rec_nxt, frz_r, frz_nxt;
  logic [31:0]  recpt_r, recpt_nxt;
  // Captured event fields.
  logic [31:0]  flight_r;
  logic [W-1:0] mssw_r;
  logic         grow_r, grow_nxt;
  logic [6:0]   fl_r, fl_nxt;  // rtx,pend,new,dbl,head (low 5 used)

  // Divider: mss*mss / cwnd, restoring, one bit per cycle.
  localparam int QB = 2 * MssBits;
  logic [QB-1:0]          quo_r, quo_nxt;
  logic [W:0]             rem_r, rem_nxt;
  logic [W-1:0]           dvs_r, dvs_nxt;
  logic [DivCntBits-1:0]  cnt_r, cnt_nxt;
  logic [QB-1:0]          sq_r;

  logic [W:0] rtrial;
  logic [W:0] rem_sh;
  logic [31:0] ld_full;
  logic [32:0] lt_thr, sum_a;
  logic [31:0] dec;
  logic [W-1:0] tmp_w;
  logic [QB-1:0] add_amt;

  always_comb begin
    logic [31:0] half, two;
    cwnd_nxt = cwnd_r; ssth_nxt = ssth_r; pwin_nxt = pwin_r;
    scwnd_nxt = scwnd_r; sssth_nxt = sssth_r; spwin_nxt = spwin_r;
    rec_nxt = rec_r; frz_nxt = frz_r; recpt_nxt = recpt_r;
    grow_nxt = grow_r; fl_nxt = fl_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    rtrial = '0; rem_sh = '0; ld_full = '0; sum_a = '0; dec = '0;
    tmp_w = '0; add_amt = '0;
    two = 32'(mss_r) << 1;
    half = ev_flight >> 1;
    lt_thr = {1'b0, (half > two) ? half : two};

    if (cmd.load) begin
      fl_nxt = '0;
      grow_nxt = 1'b0;
      case (ev_op)
        OP_OPEN: begin
          ld_full = 32'(iwnd_r) * 32'(mss_r);
          cwnd_nxt = clampw({1'b0, ld_full});
          ssth_nxt = clampw({1'b0, ithr_r});
          pwin_nxt = clampw({1'b0, ev_pwin});
          rec_nxt = 1'b0; frz_nxt = 1'b0;
        end
        OP_NEW_ACK: begin
          if (!frz_r) begin
            pwin_nxt = clampw({1'b0, ev_pwin});
            fl_nxt[1] = 1'b1;
            if (rec_r && seq_lt(ev_ack, recpt_r)) begin
              dec = ev_ack - ev_head;
              tmp_w = (33'(dec) > 33'(cwnd_r)) ? '0 : cwnd_r - W'(dec);
              cwnd_nxt = clampw(33'(tmp_w) + 33'(mss_r));
              fl_nxt[0] = 1'b1;
            end else begin
              grow_nxt = 1'b1;
            end
          end
        end
        OP_DUP_ACK: begin
          if (!frz_r) begin
            pwin_nxt = clampw({1'b0, ev_pwin});
            if (ev_dups == dupth_r && !rec_r) begin
              tmp_w = clampw(lt_thr);
              ssth_nxt = tmp_w;
              cwnd_nxt = clampw(33'(tmp_w) + 33'(mss_r) * 33'd3);
              recpt_nxt = ev_high;
              rec_nxt = 1'b1;
              fl_nxt[0] = 1'b1;
            end else if (rec_r) begin
              cwnd_nxt = clampw(33'(cwnd_r) + 33'(mss_r));
              fl_nxt[1] = 1'b1;
            end else if (ltx_r && ev_unsent) begin
              fl_nxt[2] = 1'b1;
            end
          end
        end
        OP_TIMEOUT: begin
          rec_nxt = 1'b0;
          if (!frz_r && ev_phase != PHASE_CLOSED &&
              !(ev_phase <= PHASE_ESTABLISHED && !seq_lt(ev_head, ev_high))) begin
            ssth_nxt = clampw(lt_thr);
            cwnd_nxt = clampw(33'(mss_r));
            fl_nxt[0] = 1'b1; fl_nxt[3] = 1'b1; fl_nxt[4] = 1'b1;
          end
        end
        OP_FREEZE: begin
          if (ev_phase == PHASE_ESTABLISHED && !frz_r) begin
            scwnd_nxt = cwnd_r; sssth_nxt = ssth_r; spwin_nxt = pwin_r;
            cwnd_nxt = '0; ssth_nxt = '0; pwin_nxt = '0;
            frz_nxt = 1'b1;
          end
        end
        OP_UNFREEZE: begin
          if (ev_phase == PHASE_ESTABLISHED && frz_r) begin
            cwnd_nxt = scwnd_r; ssth_nxt = sssth_r; pwin_nxt = spwin_r;
            frz_nxt = 1'b0;
            fl_nxt[1] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.ack_pre && grow_r) begin
      tmp_w = cwnd_r;
      if (rec_r) begin
        sum_a = 33'(flight_r) + 33'(mssw_r);
        tmp_w = clampw(sum_a);
        if (!(tmp_w < ssth_r)) tmp_w = ssth_r;
        rec_nxt = 1'b0;
      end
      if (tmp_w < ssth_r) begin
        cwnd_nxt = clampw(33'(tmp_w) + 33'(mssw_r));
      end else begin
        cwnd_nxt = tmp_w;
      end
      dvs_nxt = (tmp_w == '0) ? W'(1) : tmp_w;
      quo_nxt = '0;
      rem_nxt = '0;
      cnt_nxt = DivCntBits'(QB);
    end

    if (cmd.div_step) begin
      rem_sh = {rem_r[W-1:0], sq_r[cnt_r[DivCntBits-1:0] - 1'b1]};
      rtrial = rem_sh - {1'b0, dvs_r};
      if (!rtrial[W]) begin
        rem_nxt = rtrial;
        quo_nxt = {quo_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[QB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end

    if (cmd.ca_apply) begin
      add_amt = (quo_r == '0) ? QB'(1) : quo_r;
      cwnd_nxt = clampw(33'(cwnd_r) + 33'(add_amt));
    end
  end

  // Growth path chosen in the pre cycle, from the pre-update window.
  logic [W-1:0] pre_w;
  always_comb begin
    pre_w = cwnd_r;
    if (rec_r) begin
      pre_w = clampw(33'(flight_r) + 33'(mssw_r));
      if (!(pre_w < ssth_r)) pre_w = ssth_r;
    end
  end
  assign sts.need_div = grow_r && !(pre_w < ssth_r);
  assign sts.div_done = (cnt_r == DivCntBits'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwnd_r <= '0; ssth_r <= clampw(33'd65535); pwin_r <= '0;
      scwnd_r <= '0; sssth_r <= '0; spwin_r <= '0;
      rec_r <= 1'b0; frz_r <= 1'b0; recpt_r <= '0;
      grow_r <= 1'b0; cnt_r <= '0;
    end else begin
      cwnd_r <= cwnd_nxt; ssth_r <= ssth_nxt; pwin_r <= pwin_nxt;
      scwnd_r <= scwnd_nxt; sssth_r <= sssth_nxt; spwin_r <= spwin_nxt;
      rec_r <= rec_nxt; frz_r <= frz_nxt; recpt_r <= recpt_nxt;
      grow_r <= grow_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fl_r <= fl_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
    if (cmd.load) begin
      flight_r <= ev_flight;
      mssw_r <= W'(mss_r);
      sq_r <= QB'(mss_r) * QB'(mss_r);
    end
    if (cmd.emit) begin
      res_cwnd <= cwnd_r;
      res_ssth <= ssth_r;
      res_swnd <= (pwin_r < cwnd_r) ? pwin_r : cwnd_r;
      res_flags <= {fl_r[4:0], frz_r, rec_r};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tcp_newreno_window_control.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_tvalid/in_tready  | in_tdata: event fields
// out_    | output    | out_tvalid/out_tready| out_tdata: windows and flags
// cfg_    | input     | cfg_we, no wait      | cfg_addr, cfg_wdata
//
// One event is processed at a time. For most events the controller goes from the
// input transfer through the pre state to the emit state, which loads the output
// register and sets out_tvalid; the next event can transfer once back in idle.
// A new ACK that grows the window in congestion avoidance runs the mss*mss/cwnd
// restoring divider, one quotient bit per cycle for 28 bits, and applies the
// result before the emit state. Reset (rst_n low, synchronous) loads the register
// defaults and resets the connection state. The result waits in the output
// register while out_tready is low; a new event is taken only after the previous
// result has been loaded into that register, so a stalled output holds off the input.
module tcp_newreno_window_control #(
  parameter int WINDOW_BITS = tnwc_pkg::WindowBitsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[2:0], ack_number[34:3], oldest_unacked[66:35], highest_sent[98:67],
  // flight_bytes[130:99], dup_count[138:131], unsent_pending[139],
  // connection_phase[141:140], peer_window[173:142], zero fill to 175.
  input  wire logic [175:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // congestion_window, slow_start_threshold, send_window (WINDOW_BITS each),
  // then fast_recovery, is_frozen, retransmit_now, send_pending,
  // send_new_segment, double_timeout, restart_from_head, zero fill.
  output logic [((3*WINDOW_BITS+7+7)/8)*8-1:0] out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);
  import tnwc_pkg::*;

  localparam int W = WINDOW_BITS;
  localparam int OutBits = ((3 * W + 7 + 7) / 8) * 8;

  tnwc_cmd_t cmd;
  tnwc_sts_t sts;
  logic busy, in_fire, out_free;
  logic ovalid_r;
  logic [W-1:0] r_cwnd, r_ssth, r_swnd;
  logic [6:0] r_flags;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;

  tnwc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  tnwc_dp #(.WINDOW_BITS(WINDOW_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .ev_op(in_tdata[2:0]), .ev_ack(in_tdata[34:3]), .ev_head(in_tdata[66:35]),
    .ev_high(in_tdata[98:67]), .ev_flight(in_tdata[130:99]),
    .ev_dups(in_tdata[138:131]), .ev_unsent(in_tdata[139]),
    .ev_phase(in_tdata[141:140]), .ev_pwin(in_tdata[173:142]),
    .res_cwnd(r_cwnd), .res_ssth(r_ssth), .res_swnd(r_swnd), .res_flags(r_flags)
  );

  // The output valid bit follows the emit command and drops on a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.emit) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = OutBits'({r_flags, r_swnd, r_ssth, r_cwnd});
endmodule
`default_nettype wire
